FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/chol_pkg.sv
`default_nettype none
package chol_pkg;
    localparam int unsigned MAX_DIM_DEF   = 8;
    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned CFG_W         = 4;

    // divider / root unit operations
    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } chol_cmd_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 66'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/chol_divsqrt.sv
`default_nettype none
// Shared multi-cycle unit: signed restoring divide (one bit a cycle)
// or floor square root (one result bit a cycle).
module chol_divsqrt
    import chol_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire chol_cmd_t                cmd,
    input  wire logic signed [DATA_W-1:0] rem,
    input  wire logic signed [DATA_W-1:0] dvs,
    output logic                          busy,
    output logic                          done,
    output logic signed [DATA_W-1:0]      result
);
    localparam int unsigned NW   = DATA_W + FRAC_BITS;  // numerator magnitude bits
    localparam int unsigned RB   = (NW + 1) / 2;        // root bits
    localparam int unsigned CW   = $clog2(NW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              op_reg, op_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [NW-1:0]     num_reg, num_next;       // dividend bits / radicand bits
    logic [DATA_W-1:0] dv_reg, dv_next;
    logic [NW+1:0]     pr_reg, pr_next;         // partial remainder
    logic [NW-1:0]     q_reg, q_next;           // quotient / root
    logic signed [DATA_W-1:0] res_reg, res_next;

    logic [NW+1:0] trial;
    logic [NW+1:0] shifted;
    logic [NW:0]   qsign;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        dv_next   = dv_reg;
        pr_next   = pr_reg;
        q_next    = q_reg;
        res_next  = res_reg;
        trial     = '0;
        shifted   = '0;
        qsign     = '0;
        if (cmd.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            pr_next   = '0;
            q_next    = '0;
            if (cmd.op == OP_DIV)
            begin
                neg_next = rem[DATA_W-1] ^ dvs[DATA_W-1];
                num_next = {(rem[DATA_W-1] ? DATA_W'(-rem) : DATA_W'(rem)),
                            {FRAC_BITS{1'b0}}};
                dv_next  = dvs[DATA_W-1] ? DATA_W'(-dvs) : DATA_W'(dvs);
                cnt_next = CW'(NW);
            end
            else
            begin
                neg_next = 1'b0;
                num_next = {(rem[DATA_W-1] ? DATA_W'(-rem) : DATA_W'(rem)),
                            {FRAC_BITS{1'b0}}};
                dv_next  = '0;
                cnt_next = CW'(RB);
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                shifted  = {pr_reg[NW:0], num_reg[NW-1]};
                trial    = shifted - (NW+2)'(dv_reg);
                num_next = {num_reg[NW-2:0], 1'b0};
                if (!trial[NW+1])
                begin
                    pr_next = trial;
                    q_next  = {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    pr_next = shifted;
                    q_next  = {q_reg[NW-2:0], 1'b0};
                end
            end
            else
            begin
                // two radicand bits in, one root bit out
                shifted  = {pr_reg[NW-1:0], num_reg[NW-1:NW-2]};
                trial    = shifted - {q_reg[NW-1:0], 2'b01};
                num_next = {num_reg[NW-3:0], 2'b00};
                if (!trial[NW+1])
                begin
                    pr_next = trial;
                    q_next  = {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    pr_next = shifted;
                    q_next  = {q_reg[NW-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                qsign     = neg_reg ? -{1'b0, q_next} : {1'b0, q_next};
                res_next  = sat32(66'(signed'(qsign)));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        num_reg <= num_next;
        dv_reg  <= dv_next;
        pr_reg  <= pr_next;
        q_reg   <= q_next;
        res_reg <= res_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

    `include "assert_macros.svh"
    `CHK_NEXT(a_done_after_busy, done_reg, !busy_reg, "done while busy")
    `CHK_IMPL(a_start_idle, cmd.start, !busy_reg, "start while busy")
endmodule
`default_nettype wire

FILE: rtl/cholesky_decomposition_top.sv
`default_nettype none
// After the last of n*n entries, each lower entry is reduced by its product terms and then divided,
//   rooted, or saturated on a zero divisor; all entries are then emitted; one matrix at a time.
// Input accepted one item a cycle while loading; stalled during compute and emit.
// All arithmetic uses one memory port pair, one multiplier and one shared div/sqrt unit.
// Reset: size n = MAX_DIM, load count and flags cleared; matrix memory not cleared.
module cholesky_decomposition_top
    import chol_pkg::*;
#(
    parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_W-1:0]         cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [DATA_W-1:0] entry_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      factor_value,
    output logic                          last_entry,
    output logic                          negative_pivot,
    output logic                          zero_divisor
);
    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned DW    = $clog2(MAX_DIM + 1);
    localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned LW    = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_ELEM  = 4'd1;  // read a[i][j]
    localparam logic [3:0] S_RDK   = 4'd2;  // read L[i][k]
    localparam logic [3:0] S_RDK2  = 4'd3;  // read L[j][k], latch L[i][k]
    localparam logic [3:0] S_MUL   = 4'd4;  // multiply
    localparam logic [3:0] S_ACC   = 4'd5;  // accumulate
    localparam logic [3:0] S_DIAG  = 4'd6;  // read divisor, saturate sum
    localparam logic [3:0] S_START = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;
    localparam logic [3:0] S_EMRD  = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;
    localparam logic [3:0] S_ACC0  = 4'd11;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_reg;
    logic [AW-1:0]            raddr;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;

    logic [3:0]      st_reg, st_next;
    logic [CFG_W-1:0] size_reg;
    logic [DW-1:0]   n_cur;
    logic [LW-1:0]   ld_reg, ld_next;
    logic [IW-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic            neg_reg, neg_next, zs_reg, zs_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [DATA_W-1:0] lik_reg, lik_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] rem_reg, rem_next;
    logic            ov_reg, ov_next;
    logic signed [DATA_W-1:0] fv_reg, fv_next;
    logic            le_reg, le_next;
    logic            np_reg, np_next, zd_reg, zd_next;

    chol_cmd_t       cmd;
    logic            du_busy, du_done;
    logic signed [DATA_W-1:0] du_res;

    logic [LW-1:0] total;
    logic in_acc, out_acc;

    always_comb
    begin
        if (size_reg == '0)
            n_cur = DW'(1);
        else if (32'(size_reg) > MAX_DIM)
            n_cur = DW'(MAX_DIM);
        else
            n_cur = DW'(size_reg);
    end
    assign total = LW'(32'(n_cur) * 32'(n_cur));

    function automatic logic [AW-1:0] ix(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                         input logic [DW-1:0] n);
        return AW'(32'(r) * 32'(n) + 32'(c));
    endfunction

    assign in_stall = (st_reg != S_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = ov_reg && !out_stall;

    chol_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_du (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rem(rem_reg),
        .dvs(rd_reg), .busy(du_busy), .done(du_done), .result(du_res)
    );

    always_comb
    begin
        st_next  = st_reg;
        ld_next  = ld_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        neg_next = neg_reg;
        zs_next  = zs_reg;
        acc_next = acc_reg;
        lik_next = lik_reg;
        prod_next = prod_reg;
        rem_next = rem_reg;
        ov_next  = ov_reg && out_stall;
        fv_next  = fv_reg;
        le_next  = le_reg;
        np_next  = np_reg;
        zd_next  = zd_reg;
        raddr    = '0;
        we       = 1'b0;
        waddr    = '0;
        wdata    = '0;
        cmd      = '0;
        unique case (st_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    we    = 1'b1;
                    waddr = AW'(ld_reg);
                    wdata = entry_value;
                    if (ld_reg + 1'b1 >= total)
                    begin
                        ld_next = '0;
                        i_next  = '0;
                        j_next  = '0;
                        st_next = S_ELEM;
                    end
                    else
                        ld_next = ld_reg + 1'b1;
                end
            end
            S_ELEM:
            begin
                raddr   = ix(i_reg, j_reg, n_cur);
                k_next  = '0;
                st_next = S_ACC0;
            end
            S_ACC0:
            begin
                acc_next = 66'(rd_reg);
                if (j_reg == '0)
                    st_next = S_DIAG;
                else
                    st_next = S_RDK;
            end
            S_RDK:
            begin
                raddr   = ix(i_reg, k_reg, n_cur);
                st_next = S_RDK2;
            end
            S_RDK2:
            begin
                raddr    = ix(j_reg, k_reg, n_cur);
                lik_next = rd_reg;
                st_next  = S_MUL;
            end
            S_MUL:
            begin
                prod_next = 64'(lik_reg) * 64'(rd_reg);
                st_next   = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_reg - 66'(prod_reg >>> FRAC_BITS);
                if (k_reg + 1'b1 == j_reg)
                    st_next = S_DIAG;
                else
                begin
                    k_next  = k_reg + 1'b1;
                    st_next = S_RDK;
                end
            end
            S_DIAG:
            begin
                raddr    = ix(j_reg, j_reg, n_cur);
                rem_next = sat32(acc_reg);
                st_next  = S_START;
            end
            S_START:
            begin
                // rd_reg holds L[j][j]; keep it there for the wait state
                raddr = ix(j_reg, j_reg, n_cur);
                if (j_reg != i_reg && rd_reg == '0)
                begin
                    zs_next = 1'b1;
                    we      = 1'b1;
                    waddr   = ix(i_reg, j_reg, n_cur);
                    wdata   = (rem_reg > 0) ? 32'sh7FFF_FFFF :
                              ((rem_reg < 0) ? 32'sh8000_0000 : 32'sd0);
                    st_next = S_WAIT;
                end
                else
                begin
                    cmd.start = 1'b1;
                    cmd.op    = (j_reg == i_reg) ? OP_SQRT : OP_DIV;
                    if (j_reg == i_reg && rem_reg < 0)
                        neg_next = 1'b1;
                    st_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                raddr = ix(j_reg, j_reg, n_cur);
                if (du_done || (!du_busy && j_reg != i_reg && rd_reg == '0))
                begin
                    if (du_done)
                    begin
                        we    = 1'b1;
                        waddr = ix(i_reg, j_reg, n_cur);
                        wdata = du_res;
                    end
                    if (j_reg == i_reg)
                    begin
                        j_next = '0;
                        if (32'(i_reg) + 1 == 32'(n_cur))
                        begin
                            i_next  = '0;
                            st_next = S_EMRD;
                        end
                        else
                        begin
                            i_next  = i_reg + 1'b1;
                            st_next = S_ELEM;
                        end
                    end
                    else
                    begin
                        j_next  = j_reg + 1'b1;
                        st_next = S_ELEM;
                    end
                end
            end
            S_EMRD:
            begin
                raddr   = ix(i_reg, j_reg, n_cur);
                st_next = S_EMIT;
            end
            S_EMIT:
            begin
                raddr = ix(i_reg, j_reg, n_cur);
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    fv_next = (j_reg <= i_reg) ? rd_reg : '0;
                    le_next = (32'(i_reg) + 1 == 32'(n_cur)) &&
                              (32'(j_reg) + 1 == 32'(n_cur));
                    np_next = neg_reg;
                    zd_next = zs_reg;
                    if (le_next)
                    begin
                        neg_next = 1'b0;
                        zs_next  = 1'b0;
                        st_next  = S_LOAD;
                    end
                    else
                    begin
                        if (32'(j_reg) + 1 == 32'(n_cur))
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                            j_next = j_reg + 1'b1;
                        st_next = S_EMRD;
                    end
                end
            end
            default:
                st_next = S_LOAD;
        endcase
        if (cfg_we)
        begin
            ld_next  = '0;
            neg_next = 1'b0;
            zs_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_LOAD;
            size_reg <= CFG_W'(MAX_DIM);
            ld_reg   <= '0;
            neg_reg  <= 1'b0;
            zs_reg   <= 1'b0;
            ov_reg   <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
            ld_reg  <= ld_next;
            neg_reg <= neg_next;
            zs_reg  <= zs_next;
            ov_reg  <= ov_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
            k_reg   <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        lik_reg  <= lik_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        fv_reg   <= fv_next;
        le_reg   <= le_next;
        np_reg   <= np_next;
        zd_reg   <= zd_next;
    end

    assign out_valid      = ov_reg;
    assign factor_value   = fv_reg;
    assign last_entry     = le_reg;
    assign negative_pivot = np_reg;
    assign zero_divisor   = zd_reg;

    `include "assert_macros.svh"
    `CHK_IMPL(a_no_load_in_compute, in_acc, st_reg == S_LOAD, "item taken outside load")
    `CHK_NEXT(a_hold_stalled, ov_reg && out_stall, ov_reg && $stable(fv_reg), "stalled result changed")
    `CHK_IMPL(a_ld_in_range, st_reg == S_LOAD, ld_reg < total, "load count out of range")
endmodule
`default_nettype wire
